// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/brpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Banked ramdisk port engine package
// Port codes, register indexes and reset values shared by the engine.
// ----------------------------------------------------------------------------
package brpe_pkg;

   localparam int unsigned DEFAULT_BANKS = 16;
   localparam int unsigned BANK_BYTES    = 65536;

   // access direction
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // port low byte codes
   localparam logic [7:0] PORT_BANK   = 8'hE9;
   localparam logic [7:0] PORT_DATA   = 8'hEA;
   localparam logic [7:0] PORT_OFFSET = 8'hEB;
   localparam logic [7:0] PORT_RESET  = 8'hF8;
   localparam logic [7:0] PORT_SRD    = 8'hF9;
   localparam logic [7:0] PORT_SWR    = 8'hFA;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BANK_MASK     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_PROTECT = 2'd1;

   localparam logic [7:0] BANK_MASK_RESET = 8'd15;
   localparam logic [7:0] ERASED_BYTE     = 8'hFF;

   typedef struct packed {
      logic       from_mem;
      logic [7:0] fixed;
   } rsp_sel_type;

endpackage

// ===== design/banked_ramdisk_port_engine.sv =====
// ----------------------------------------------------------------------------
// Banked ramdisk port engine
// Port-decoded byte store of BANKS banks of 64K with auto-advancing offset.
// ----------------------------------------------------------------------------
// One port access is accepted per clock while busy is low. A read gives its
// byte on rsp_read_data with rsp_valid high in the cycle after it is accepted
// (the store's read port is registered); a write gives nothing. Results must
// be taken as they come. After reset, busy stays high while the store is
// filled with 0xFF, one byte per cycle; configuration writes are taken
// throughout.
`include "assert_macros.svh"

module banked_ramdisk_port_engine
   import brpe_pkg::*;
#(
   parameter int unsigned BANKS = DEFAULT_BANKS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_mode,
   input  logic [7:0]           req_port_low,
   input  logic [7:0]           req_port_high,
   input  logic [7:0]           req_write_data,
   input  logic [7:0]           req_bus_latch,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_read_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   localparam int unsigned BANK_BITS = (BANKS > 1) ? $clog2(BANKS) : 1;
   localparam int unsigned ADDR_W    = BANK_BITS + 16;
   localparam int unsigned MEM_DEPTH = BANKS * BANK_BYTES;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);
   localparam logic [8:0]        BANK_LIMIT = 9'(BANKS);

   logic [7:0]        store_mem [MEM_DEPTH];

   logic [7:0]        bank_mask_ff, bank_mask_in;
   logic              write_protect_ff, write_protect_in;
   logic [7:0]        bank_ff, bank_in;
   logic [15:0]       offset_ff, offset_in;
   logic              clear_ff, clear_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_sel_type       rsp_sel_ff, rsp_sel_in;
   logic [7:0]        mem_rdata_ff;

   logic              accept;
   logic              present;
   logic              data_access;
   logic              item_we;
   logic [ADDR_W-1:0] item_addr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;

   assign busy      = clear_ff;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign present   = {1'b0, bank_ff} < BANK_LIMIT;
   assign item_addr = {bank_ff[BANK_BITS-1:0], offset_ff};

   // configuration registers
   always_comb begin
      bank_mask_in     = bank_mask_ff;
      write_protect_in = write_protect_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BANK_MASK:     bank_mask_in     = csr_wdata;
            CSR_WRITE_PROTECT: write_protect_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // port decode
   always_comb begin
      bank_in      = bank_ff;
      offset_in    = offset_ff;
      item_we      = 1'b0;
      data_access  = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_sel_in   = '{from_mem: 1'b0, fixed: 8'd0};
      if (accept) begin
         if (req_mode == MODE_WRITE) begin
            unique case (req_port_low) inside
               PORT_BANK:   bank_in   = req_write_data & bank_mask_ff;
               PORT_OFFSET: offset_in = {req_port_high, req_write_data};
               PORT_DATA, PORT_SWR: begin
                  data_access = 1'b1;
                  item_we     = present && !write_protect_ff;
               end
               default: ;
            endcase
         end else begin
            rsp_valid_in = 1'b1;
            unique case (req_port_low) inside
               PORT_RESET: begin
                  bank_in          = 8'd0;
                  offset_in        = 16'd0;
                  rsp_sel_in.fixed = req_bus_latch;
               end
               PORT_DATA, PORT_SRD: begin
                  data_access         = 1'b1;
                  rsp_sel_in.from_mem = present;
                  rsp_sel_in.fixed    = ERASED_BYTE;
               end
               default: ;
            endcase
         end
         if (data_access) begin
            offset_in = offset_ff + 16'd1;
         end
      end
   end

   // fill sweep after reset
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == LAST_ADDR) begin
            clear_in = 1'b0;
         end
      end
   end

   assign mem_we    = clear_ff || item_we;
   assign mem_waddr = clear_ff ? clear_addr_ff : item_addr;
   assign mem_wdata = clear_ff ? ERASED_BYTE : req_write_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= store_mem[item_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_mask_ff     <= BANK_MASK_RESET;
         write_protect_ff <= 1'b0;
         bank_ff          <= 8'd0;
         offset_ff        <= 16'd0;
         clear_ff         <= 1'b1;
         clear_addr_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         bank_mask_ff     <= bank_mask_in;
         write_protect_ff <= write_protect_in;
         bank_ff          <= bank_in;
         offset_ff        <= offset_in;
         clear_ff         <= clear_in;
         clear_addr_ff    <= clear_addr_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rsp_sel_ff <= rsp_sel_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_sel_ff.from_mem ? mem_rdata_ff : rsp_sel_ff.fixed;

   `ASSERT_NEXT(a_read_gives_item, clock, reset, accept && req_mode == MODE_READ, rsp_valid)
   `ASSERT_NEXT(a_no_stray_item, clock, reset, !(accept && req_mode == MODE_READ), !rsp_valid)
   `ASSERT_IMPLIES(a_sweep_writes_erased, clock, reset, clear_ff, mem_we && mem_wdata == ERASED_BYTE)
   `ASSERT_NEXT(a_offset_advances, clock, reset, accept && data_access, offset_ff == $past(offset_ff) + 16'd1)
   `ASSERT_IMPLIES(a_no_store_absent_bank, clock, reset, item_we, present && !write_protect_ff)

endmodule
